### rtl/exp_ts_pkg.sv
// ----------------------------------------------------------------------------
// exp_ts_pkg
// Types, widths, control-word layout and the microcode program of the
// exponential series engine.
// ----------------------------------------------------------------------------
package exp_ts_pkg;

  localparam int MAX_TERMS_DEF     = 64;
  localparam int FRACTION_BITS_DEF = 24;

  localparam int X_W        = 29;   // argument width
  localparam int EPS_W      = 25;   // threshold width
  localparam int Y_W        = 64;   // sum width
  localparam int TERMS_W    = 7;    // terms_used width
  localparam int T_W        = 63;   // term magnitude width
  localparam int TLO_W      = 32;
  localparam int THI_W      = T_W - TLO_W;
  localparam int PP_W       = TLO_W + X_W;   // one partial product
  localparam int PROD_W     = T_W + X_W;     // full product
  localparam int DIV_RADIX  = 8;             // quotient bits per cycle

  localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(16);

  typedef logic [3:0] step_t;

  localparam step_t ST_IDLE  = 4'd0;
  localparam step_t ST_CHECK = 4'd1;
  localparam step_t ST_LIMIT = 4'd2;
  localparam step_t ST_MULLO = 4'd3;
  localparam step_t ST_MULHI = 4'd4;
  localparam step_t ST_SHIFT = 4'd5;
  localparam step_t ST_DIV   = 4'd6;
  localparam step_t ST_TERM  = 4'd7;
  localparam step_t ST_SUM   = 4'd8;
  localparam step_t ST_EMIT  = 4'd9;
  localparam step_t ST_WRAP  = 4'd10;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_LIMIT,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_SHIFT,
    OP_DIV,
    OP_TERM,
    OP_SUM,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    JMP_NEVER,
    JMP_ALWAYS,
    JMP_NO_INPUT,
    JMP_T_SMALL,
    JMP_K_LIMIT,
    JMP_DIV_BUSY,
    JMP_OUT_BUSY
  } jmp_e;

  typedef struct packed {
    op_e   op;
    jmp_e  jmp;
    step_t target;
  } ucode_t;

  typedef struct packed {
    logic in_valid;
    logic t_small;
    logic k_limit;
    logic div_busy;
    logic out_busy;
  } status_t;

  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    case (s)
      ST_IDLE:  w = '{op: OP_LOAD,   jmp: JMP_NO_INPUT, target: ST_IDLE};
      ST_CHECK: w = '{op: OP_NOP,    jmp: JMP_T_SMALL,  target: ST_EMIT};
      ST_LIMIT: w = '{op: OP_LIMIT,  jmp: JMP_K_LIMIT,  target: ST_EMIT};
      ST_MULLO: w = '{op: OP_MUL_LO, jmp: JMP_NEVER,    target: ST_IDLE};
      ST_MULHI: w = '{op: OP_MUL_HI, jmp: JMP_NEVER,    target: ST_IDLE};
      ST_SHIFT: w = '{op: OP_SHIFT,  jmp: JMP_NEVER,    target: ST_IDLE};
      ST_DIV:   w = '{op: OP_DIV,    jmp: JMP_DIV_BUSY, target: ST_DIV};
      ST_TERM:  w = '{op: OP_TERM,   jmp: JMP_NEVER,    target: ST_IDLE};
      ST_SUM:   w = '{op: OP_SUM,    jmp: JMP_ALWAYS,   target: ST_CHECK};
      ST_EMIT:  w = '{op: OP_EMIT,   jmp: JMP_OUT_BUSY, target: ST_EMIT};
      ST_WRAP:  w = '{op: OP_NOP,    jmp: JMP_ALWAYS,   target: ST_IDLE};
      default:  w = '{op: OP_NOP,    jmp: JMP_ALWAYS,   target: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

### rtl/exp_ts_if.sv
// ----------------------------------------------------------------------------
// exp_ts_if
// Valid/ready channels of the exponential series engine: argument in,
// result out.
// ----------------------------------------------------------------------------
interface exp_ts_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [exp_ts_pkg::X_W-1:0]   x_value;

  modport source (output valid, output x_value, input ready);
  modport sink   (input valid, input x_value, output ready);
endinterface

interface exp_ts_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [exp_ts_pkg::Y_W-1:0]     exp_value;
  logic        [exp_ts_pkg::TERMS_W-1:0] terms_used;
  logic                                  limit_hit;
  logic                                  saturated;

  modport source (output valid, output exp_value, output terms_used,
                  output limit_hit, output saturated, input ready);
  modport sink   (input valid, input exp_value, input terms_used,
                  input limit_hit, input saturated, output ready);
endinterface

### rtl/exp_ts_seq.sv
// ----------------------------------------------------------------------------
// exp_ts_seq
// Microcode sequencer: step counter, control-word rom and conditional jumps.
// ----------------------------------------------------------------------------
module exp_ts_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  exp_ts_pkg::status_t  status_i,
  output exp_ts_pkg::ucode_t   ucode_o
);

  exp_ts_pkg::step_t  step_q, step_d;
  exp_ts_pkg::ucode_t word;
  logic               take_jump;

  always_comb begin
    word = exp_ts_pkg::ucode_rom(step_q);
    case (word.jmp)
      exp_ts_pkg::JMP_NEVER:    take_jump = 1'b0;
      exp_ts_pkg::JMP_ALWAYS:   take_jump = 1'b1;
      exp_ts_pkg::JMP_NO_INPUT: take_jump = !status_i.in_valid;
      exp_ts_pkg::JMP_T_SMALL:  take_jump = status_i.t_small;
      exp_ts_pkg::JMP_K_LIMIT:  take_jump = status_i.k_limit;
      exp_ts_pkg::JMP_DIV_BUSY: take_jump = status_i.div_busy;
      exp_ts_pkg::JMP_OUT_BUSY: take_jump = status_i.out_busy;
      default:                  take_jump = 1'b1;
    endcase
    step_d  = take_jump ? word.target : step_q + 4'd1;
    ucode_o = word;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= exp_ts_pkg::ST_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

### rtl/exp_taylor_series.sv
// ----------------------------------------------------------------------------
// exp_taylor_series
// e^x by Taylor series in fixed point, one term per pass of a microcode loop
// over a shared 32x29 multiplier and a radix-256 divider by the term index.
// ----------------------------------------------------------------------------
// per term: check, limit, low and high partial products, shift, divide, new term,
//   sum; the loop ends when the term is at or below eps_threshold or at the term limit
// flow: one argument at a time; the next is taken while the output register may
//   still hold the last result
// reset: sequencer to idle, no result pending, eps_threshold back to 16
module exp_taylor_series #(
  parameter int MAX_TERMS     = exp_ts_pkg::MAX_TERMS_DEF,
  parameter int FRACTION_BITS = exp_ts_pkg::FRACTION_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [exp_ts_pkg::EPS_W-1:0]   cfg_wdata_i,
  exp_ts_in_if.sink                      x_chan_i,
  exp_ts_out_if.source                   res_chan_o
);

  localparam int T_W    = exp_ts_pkg::T_W;
  localparam int X_W    = exp_ts_pkg::X_W;
  localparam int Y_W    = exp_ts_pkg::Y_W;
  localparam int PP_W   = exp_ts_pkg::PP_W;
  localparam int PROD_W = exp_ts_pkg::PROD_W;
  localparam int TLO_W  = exp_ts_pkg::TLO_W;
  localparam int RADIX  = exp_ts_pkg::DIV_RADIX;
  localparam int KW     = $clog2(MAX_TERMS + 1);
  localparam int DIV_STEPS = (PROD_W - FRACTION_BITS + RADIX - 1) / RADIX;
  localparam int DW     = DIV_STEPS * RADIX;
  localparam int DCW    = $clog2(DIV_STEPS + 1);

  exp_ts_pkg::ucode_t  uc;
  exp_ts_pkg::status_t st;

  logic [exp_ts_pkg::EPS_W-1:0] eps_q;

  logic [X_W-1:0]         x_mag_q;
  logic                   x_neg_q;
  logic [T_W-1:0]         t_mag_q;
  logic                   t_neg_q;
  logic signed [Y_W-1:0]  y_q;
  logic [KW-1:0]          k_q;
  logic                   sat_q;
  logic                   limit_q;
  logic [PP_W-1:0]        prod_q;
  logic [PROD_W-1:0]      acc_q;
  logic [DW-1:0]          quo_q, quo_d;
  logic [KW-1:0]          rem_q, rem_d;
  logic [DCW-1:0]         div_cnt_q;

  logic signed [Y_W-1:0]              out_y_q;
  logic [exp_ts_pkg::TERMS_W-1:0]     out_terms_q;
  logic                               out_limit_q;
  logic                               out_sat_q;
  logic                               out_valid_q;

  logic                   in_take;
  logic                   emit;
  logic [X_W-1:0]         x_raw;
  logic [X_W-1:0]         x_mag_in;
  logic [PROD_W-1:0]      prod_sum;
  logic [PROD_W-1:0]      prod_shr;
  logic                   quo_over;
  logic [T_W-1:0]         t_next;
  logic signed [Y_W-1:0]  t_signed;
  logic signed [Y_W:0]    y_sum;
  logic signed [Y_W-1:0]  y_next;
  logic                   y_ovf;
  logic [15:0]            k_wide;

  exp_ts_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (st),
    .ucode_o  (uc)
  );

  // handshake
  assign x_chan_i.ready = (uc.op == exp_ts_pkg::OP_LOAD);
  assign in_take        = x_chan_i.ready && x_chan_i.valid;
  assign emit           = (uc.op == exp_ts_pkg::OP_EMIT) && !st.out_busy;

  always_comb begin
    st.in_valid = x_chan_i.valid;
    st.t_small  = t_mag_q <= T_W'(eps_q);
    st.k_limit  = k_q >= KW'(MAX_TERMS);
    st.div_busy = div_cnt_q != DCW'(1);
    st.out_busy = out_valid_q && !res_chan_o.ready;
  end

  assign x_raw    = x_chan_i.x_value;
  assign x_mag_in = x_raw[X_W-1] ? X_W'(-x_raw) : x_raw;

  // product of both partial products, back to FRACTION_BITS fraction bits
  assign prod_sum = acc_q + (PROD_W'(prod_q) << TLO_W);
  assign prod_shr = prod_sum >> FRACTION_BITS;

  // radix-256 restoring division of the quotient register by k
  always_comb begin
    logic [KW:0]   trial;
    logic [DW-1:0] q_v;
    logic [KW-1:0] r_v;
    q_v = quo_q;
    r_v = rem_q;
    for (int i = 0; i < RADIX; i++) begin
      trial = {r_v, q_v[DW-1]};
      q_v   = {q_v[DW-2:0], 1'b0};
      if (trial >= {1'b0, k_q}) begin
        trial  = trial - {1'b0, k_q};
        q_v[0] = 1'b1;
      end
      r_v = trial[KW-1:0];
    end
    quo_d = q_v;
    rem_d = r_v;
  end

  assign quo_over = |quo_q[DW-1:T_W];
  assign t_next   = quo_over ? {T_W{1'b1}} : quo_q[T_W-1:0];

  // saturating accumulate of the signed term
  assign t_signed = t_neg_q ? -$signed({1'b0, t_mag_q}) : $signed({1'b0, t_mag_q});
  assign y_sum    = {y_q[Y_W-1], y_q} + {t_signed[Y_W-1], t_signed};
  assign y_ovf    = y_sum[Y_W] != y_sum[Y_W-1];
  assign y_next   = !y_ovf ? y_sum[Y_W-1:0] :
                    y_sum[Y_W] ? {1'b1, {(Y_W-1){1'b0}}} : {1'b0, {(Y_W-1){1'b1}}};

  assign k_wide = 16'(k_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= exp_ts_pkg::EPS_RESET;
    end else if (cfg_we_i) begin
      eps_q <= cfg_wdata_i;
    end
  end

  // datapath registers, driven by the control word
  always_ff @(posedge clk_i) begin
    case (uc.op)
      exp_ts_pkg::OP_LOAD: begin
        if (in_take) begin
          x_mag_q <= x_mag_in;
          x_neg_q <= x_raw[X_W-1];
          t_mag_q <= T_W'(1) << FRACTION_BITS;
          t_neg_q <= 1'b0;
          y_q     <= Y_W'(1) << FRACTION_BITS;
          k_q     <= '0;
          sat_q   <= 1'b0;
          limit_q <= 1'b0;
        end
      end
      exp_ts_pkg::OP_LIMIT: begin
        if (st.k_limit) begin
          limit_q <= 1'b1;
        end
      end
      exp_ts_pkg::OP_MUL_LO: begin
        k_q    <= k_q + KW'(1);
        prod_q <= PP_W'(t_mag_q[TLO_W-1:0] * x_mag_q);
      end
      exp_ts_pkg::OP_MUL_HI: begin
        acc_q  <= PROD_W'(prod_q);
        prod_q <= PP_W'(t_mag_q[T_W-1:TLO_W] * x_mag_q);
      end
      exp_ts_pkg::OP_SHIFT: begin
        quo_q     <= prod_shr[DW-1:0];
        rem_q     <= '0;
        div_cnt_q <= DCW'(DIV_STEPS);
      end
      exp_ts_pkg::OP_DIV: begin
        quo_q     <= quo_d;
        rem_q     <= rem_d;
        div_cnt_q <= div_cnt_q - DCW'(1);
      end
      exp_ts_pkg::OP_TERM: begin
        t_mag_q <= t_next;
        t_neg_q <= t_neg_q ^ x_neg_q;
        if (quo_over) begin
          sat_q <= 1'b1;
        end
      end
      exp_ts_pkg::OP_SUM: begin
        y_q <= y_next;
        if (y_ovf) begin
          sat_q <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (res_chan_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_y_q     <= y_q;
      out_terms_q <= k_wide[exp_ts_pkg::TERMS_W-1:0];
      out_limit_q <= limit_q;
      out_sat_q   <= sat_q;
    end
  end

  assign res_chan_o.valid      = out_valid_q;
  assign res_chan_o.exp_value  = out_y_q;
  assign res_chan_o.terms_used = out_terms_q;
  assign res_chan_o.limit_hit  = out_limit_q;
  assign res_chan_o.saturated  = out_sat_q;

endmodule

### test/exp_taylor_series_tb.sv
// ----------------------------------------------------------------------------
// exp_taylor_series_tb
// Drives arguments into the exponential series engine under random input
// gaps and output stalls, predicts each e^x sum, term count and flags with
// a fixed-point series evaluator of its own, and checks every result beat
// in order. The threshold register is swept across its extremes.
// ----------------------------------------------------------------------------
module exp_taylor_series_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          X_W        = exp_ts_pkg::X_W;
  localparam int          EPS_W      = exp_ts_pkg::EPS_W;
  localparam int          Y_W        = exp_ts_pkg::Y_W;
  localparam int          TERMS_W    = exp_ts_pkg::TERMS_W;
  localparam int          T_W        = exp_ts_pkg::T_W;
  localparam int          N_TERMS    = exp_ts_pkg::MAX_TERMS_DEF;
  localparam int          FRAC       = exp_ts_pkg::FRACTION_BITS_DEF;
  localparam int          PHASES     = 8;
  localparam int          PHASE_ARGS = 200;
  localparam int unsigned CYCLE_MAX  = 12_000_000;

  typedef logic signed [X_W-1:0] arg_t;
  typedef logic [EPS_W-1:0]      eps_t;

  typedef struct packed {
    logic signed [Y_W-1:0] exp_value;
    logic [TERMS_W-1:0]    terms_used;
    logic                  limit_hit;
    logic                  saturated;
  } series_res_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  eps_t cfg_wdata_i;

  exp_ts_in_if  x_if ();
  exp_ts_out_if res_if ();

  eps_t          eps_cur;
  series_res_t   sum_q[$];
  int unsigned   mismatch_cnt;
  int unsigned   cycle_cnt;
  bit            gaps_on;

  exp_taylor_series u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .x_chan_i    (x_if),
    .res_chan_o  (res_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // series evaluation: t' = trunc(|t|*|x| / (2^FRAC * k)) with sign, summed
  function automatic series_res_t series_sum(arg_t x, eps_t eps);
    series_res_t           r;
    logic                  x_neg;
    logic                  t_neg;
    logic [X_W-1:0]        x_mag;
    logic [T_W-1:0]        t_mag;
    logic [127:0]          prod;
    logic [127:0]          quo;
    logic signed [Y_W-1:0] y;
    logic signed [Y_W-1:0] t;
    logic [Y_W:0]          acc;
    int unsigned           k;
    x_neg = x[X_W-1];
    x_mag = x_neg ? (~x + 1'b1) : x;
    t_mag = T_W'(1) << FRAC;
    t_neg = 1'b0;
    y = Y_W'(1) << FRAC;
    k = 0;
    r = '0;
    while (t_mag > T_W'(eps)) begin
      if (k >= N_TERMS) begin
        r.limit_hit = 1'b1;
        break;
      end
      k++;
      prod = 128'(t_mag) * 128'(x_mag);
      quo = (prod >> FRAC) / 128'(k);
      if (quo > 128'({T_W{1'b1}})) begin
        t_mag = '1;
        r.saturated = 1'b1;
      end else begin
        t_mag = quo[T_W-1:0];
      end
      t_neg = t_neg ^ x_neg;
      t = t_neg ? -$signed({1'b0, t_mag}) : $signed({1'b0, t_mag});
      acc = {y[Y_W-1], y} + {t[Y_W-1], t};
      if (acc[Y_W] != acc[Y_W-1]) begin
        // clamp toward the side the true sum lies on
        y = acc[Y_W] ? {1'b1, {(Y_W-1){1'b0}}} : {1'b0, {(Y_W-1){1'b1}}};
        r.saturated = 1'b1;
      end else begin
        y = acc[Y_W-1:0];
      end
    end
    r.exp_value  = y;
    r.terms_used = TERMS_W'(k);
    return r;
  endfunction

  // one argument beat; valid stays high into the next call unless a gap comes
  task automatic send_arg(arg_t x);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      x_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    x_if.valid   <= 1'b1;
    x_if.x_value <= x;
    do @(posedge clk_i); while (!x_if.ready);
    sum_q.push_back(series_sum(x, eps_cur));
  endtask

  // hold off the sender until every outstanding sum has come back
  task automatic drain();
    while (sum_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_eps(eps_t v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    eps_cur  = v;
  endtask

  task automatic test_directed_args();
    arg_t args[$];
    args = '{arg_t'(0), arg_t'(1), -arg_t'(1), arg_t'(1 << FRAC), -arg_t'(1 << FRAC),
             {1'b0, {(X_W-1){1'b1}}}, {1'b1, {(X_W-1){1'b0}}}, arg_t'(29'h0AAA_AAAA),
             arg_t'(29'h1555_5555), arg_t'(3 << (FRAC - 1)), -arg_t'(5 << FRAC),
             arg_t'(10 << FRAC)};
    foreach (args[i]) send_arg(args[i]);
    x_if.valid <= 1'b0;
    drain();
  endtask

  // zero threshold runs to an exact zero term or the term limit; a threshold
  // at or above 1.0 stops before the first term
  task automatic test_eps_extremes();
    eps_t eps_set[$];
    eps_set = '{eps_t'(0), eps_t'(1), eps_t'((1 << FRAC) - 1), eps_t'(1 << FRAC), '1};
    foreach (eps_set[i]) begin
      write_eps(eps_set[i]);
      send_arg({1'b0, {(X_W-1){1'b1}}});
      send_arg({1'b1, {(X_W-1){1'b0}}});
      send_arg(arg_t'($urandom_range(0, 1 << FRAC)));
      x_if.valid <= 1'b0;
      drain();
    end
  endtask

  task automatic test_random_args();
    arg_t x;
    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(0, 3))
        0: write_eps(eps_t'($urandom_range(0, 255)));
        1: write_eps(eps_t'($urandom));
        2: write_eps(eps_t'($urandom_range(0, 1 << 16)));
        default: write_eps(eps_t'(16));
      endcase
      // the last phase runs flat out on both sides
      gaps_on = (p != PHASES - 1);
      for (int n = 0; n < PHASE_ARGS; n++) begin
        if ($urandom_range(0, 1) == 0) begin
          x = arg_t'($urandom);
        end else begin
          x = arg_t'($urandom_range(0, 1 << (FRAC + 2)));
          if ($urandom_range(0, 1) == 1) x = -x;
        end
        send_arg(x);
      end
      x_if.valid <= 1'b0;
      drain();
    end
  endtask

  // result side: random stall bursts while gaps are enabled
  initial begin
    res_if.ready = 1'b1;
    forever begin
      @(posedge clk_i);
      if (gaps_on && $urandom_range(0, 7) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    series_res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (sum_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result beat: exp_value=%0d terms_used=%0d", res_if.exp_value,
                   res_if.terms_used);
      end else begin
        want = sum_q.pop_front();
        if (res_if.exp_value !== want.exp_value || res_if.terms_used !== want.terms_used ||
            res_if.limit_hit !== want.limit_hit || res_if.saturated !== want.saturated) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: exp_value=%0d/%0d terms_used=%0d/%0d limit_hit=%0b/%0b %s",
                     res_if.exp_value, want.exp_value, res_if.terms_used, want.terms_used,
                     res_if.limit_hit, want.limit_hit,
                     $sformatf("saturated=%0b/%0b (got/expected)", res_if.saturated,
                               want.saturated));
        end
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_MAX) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    x_if.valid   = 1'b0;
    x_if.x_value = '0;
    eps_cur      = exp_ts_pkg::EPS_RESET;
    mismatch_cnt = 0;
    gaps_on      = 1'b1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_args();
    test_eps_extremes();
    test_random_args();
    drain();
    repeat (100) @(posedge clk_i);
    if (mismatch_cnt == 0 && sum_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
